// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame receiver modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sofr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sofr_pkg
// Constants and types of the start-byte framed message receiver.
// ---------------------------------------------------------------------------
package sofr_pkg;

  localparam logic [7:0] START_BYTE       = 8'hA5;
  localparam int         MAX_TARGETS      = 16;
  localparam int         PAYLOAD_CAPACITY = 64;
  localparam int         TGT_CNT_W        = 5;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_EMPTY_END = 1'b1;

  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } sofr_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] target_id;
    logic [7:0] command;
    logic [7:0] frame_length;
    logic [7:0] position;
    logic [7:0] payload_byte;
    logic       within_capacity;
    logic       frame_done;
    logic       target_valid;
  } sofr_result_t;

endpackage

// ===== src/sofr_in_stage.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sofr_in_stage
// Input register: captures one received byte per transaction.
// ---------------------------------------------------------------------------
module sofr_in_stage
  import sofr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte[7:0]
  input  logic       adv,
  output sofr_item_t item
);

  logic       vld_r;
  logic [7:0] byte_r;

  assign in_tready    = !vld_r || adv;
  assign item.vld     = vld_r;
  assign item.rx_byte = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  `ASSERT_CLK(a_hold_unconsumed, vld_r && !adv |=> vld_r, "held byte lost before consumption")

endmodule

// ===== src/sofr_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sofr_parser
// Frame state machine: hunts for the start byte, latches the header and
// forms one result per payload byte or per empty frame.
// ---------------------------------------------------------------------------
module sofr_parser
  import sofr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TGT_CNT_W-1:0] cfg_wr_data,
  input  sofr_item_t           item,
  input  logic                 out_free,
  output logic                 adv,
  output logic                 res_vld,
  output sofr_result_t         res
);

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_TARGET  = 3'd1,
    ST_COMMAND = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_DATA    = 3'd4
  } state_t;

  state_t               state_r, state_nxt;
  logic [7:0]           held_target_r, held_target_nxt;
  logic [7:0]           held_command_r, held_command_nxt;
  logic [7:0]           held_length_r, held_length_nxt;
  logic [7:0]           byte_index_r, byte_index_nxt;
  logic [TGT_CNT_W-1:0] reg_targets_r;
  logic                 has_res;
  logic [7:0]           index_inc;

  assign index_inc = byte_index_r + 8'd1;

  always_comb begin
    state_nxt        = state_r;
    held_target_nxt  = held_target_r;
    held_command_nxt = held_command_r;
    held_length_nxt  = held_length_r;
    byte_index_nxt   = byte_index_r;
    has_res          = 1'b0;

    res.kind            = KIND_PAYLOAD;
    res.target_id       = held_target_r;
    res.command         = held_command_r;
    res.frame_length    = held_length_r;
    res.position        = byte_index_r;
    res.payload_byte    = item.rx_byte;
    res.within_capacity = byte_index_r < 8'(PAYLOAD_CAPACITY);
    res.frame_done      = index_inc == held_length_r;
    res.target_valid    = (held_target_r < {{(8-TGT_CNT_W){1'b0}}, reg_targets_r}) &&
                          (held_target_r < 8'(MAX_TARGETS));

    unique case (state_r)
      ST_HUNT: begin
        if (item.rx_byte == START_BYTE) begin
          state_nxt = ST_TARGET;
        end
      end
      ST_TARGET: begin
        held_target_nxt = item.rx_byte;
        state_nxt       = ST_COMMAND;
      end
      ST_COMMAND: begin
        held_command_nxt = item.rx_byte;
        state_nxt        = ST_LENGTH;
      end
      ST_LENGTH: begin
        held_length_nxt = item.rx_byte;
        byte_index_nxt  = 8'd0;
        if (item.rx_byte == 8'd0) begin
          // empty frame: report against the header just completed
          has_res             = 1'b1;
          res.kind            = KIND_EMPTY_END;
          res.frame_length    = 8'd0;
          res.position        = 8'd0;
          res.payload_byte    = 8'd0;
          res.within_capacity = 1'b0;
          res.frame_done      = 1'b1;
          state_nxt           = ST_HUNT;
        end else begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        has_res        = 1'b1;
        byte_index_nxt = index_inc;
        if (res.frame_done) begin
          state_nxt = ST_HUNT;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // consume the held byte unless its result has nowhere to go
  assign adv     = item.vld && (!has_res || out_free);
  assign res_vld = adv && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_HUNT;
      held_target_r  <= 8'd0;
      held_command_r <= 8'd0;
      held_length_r  <= 8'd0;
      byte_index_r   <= 8'd0;
      reg_targets_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        reg_targets_r <= cfg_wr_data;
      end
      if (adv) begin
        state_r        <= state_nxt;
        held_target_r  <= held_target_nxt;
        held_command_r <= held_command_nxt;
        held_length_r  <= held_length_nxt;
        byte_index_r   <= byte_index_nxt;
      end
    end
  end

  `ASSERT_ALWAYS(a_index_in_frame, state_r == ST_DATA |-> byte_index_r < held_length_r, "payload index beyond frame length")
  `ASSERT_CLK(a_done_to_hunt, res_vld && res.frame_done |=> state_r == ST_HUNT, "frame end did not return to hunting")
  `ASSERT_CLK(a_empty_end, res_vld && res.kind == KIND_EMPTY_END |-> res.frame_done && res.position == 8'd0, "empty frame result malformed")

endmodule

// ===== src/sofr_out_stage.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sofr_out_stage
// Result register: holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module sofr_out_stage
  import sofr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_vld,
  input  sofr_result_t res,
  output logic         out_free,
  output logic         out_tvalid,
  input  logic         out_tready,
  output sofr_result_t out_res
);

  logic         vld_r;
  sofr_result_t res_r;

  assign out_free   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= res_vld;
    end
    if (res_vld) begin
      res_r <= res;
    end
  end

  `ASSERT_CLK(a_no_overwrite, res_vld |-> out_free, "result loaded over a pending one")

endmodule

// ===== src/sof_length_frame_receiver.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register, and its result, if any, is
// registered in the output stage once that stage is free to take it.
// Throughput: one byte per cycle unless a result waits on a full output stage.
// Header bytes and bytes dropped while hunting give no result and do not wait for the output.
// Reset (rst_n low, synchronous): hunting for the start byte, header fields and
// payload index zero, registered target count zero, both stages empty.
// ---------------------------------------------------------------------------
// sof_length_frame_receiver
// Frames a byte stream into start-byte, length-prefixed messages and reports
// each payload byte and each empty frame with its header fields.
// ---------------------------------------------------------------------------
module sof_length_frame_receiver
  import sofr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TGT_CNT_W-1:0] cfg_wr_data,   // registered_targets[4:0]
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,      // rx_byte[7:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // target_id[7:0], command[15:8], frame_length[23:16], position[31:24],
  // payload_byte[39:32], within_capacity[40], target_valid[41], zero[47:42]
  output logic [47:0]          out_tdata,
  output logic                 out_tlast,     // frame_done
  output logic                 out_tuser      // kind
);

  sofr_item_t   item;
  sofr_result_t res;
  sofr_result_t out_res;
  logic         adv;
  logic         res_vld;
  logic         out_free;

  sofr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .item      (item)
  );

  sofr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .out_free    (out_free),
    .adv         (adv),
    .res_vld     (res_vld),
    .res         (res)
  );

  sofr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {6'b0, out_res.target_valid, out_res.within_capacity,
                      out_res.payload_byte, out_res.position, out_res.frame_length,
                      out_res.command, out_res.target_id};
  assign out_tlast = out_res.frame_done;
  assign out_tuser = out_res.kind;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the start-byte framed receiver. Sends directed and
// random frames, line noise and broken headers under random stalls on both
// stream sides. It tracks the frame state per accepted byte to predict every
// payload and empty-frame report, and compares each report field by field.
// ---------------------------------------------------------------------------
import sofr_pkg::*;

typedef enum logic [2:0] {
  HUNT_START,
  GET_TARGET,
  GET_COMMAND,
  GET_LENGTH,
  GET_PAYLOAD
} rx_phase_t;

class frame_checker;
  sofr_result_t expected_q[$];
  rx_phase_t    phase = HUNT_START;
  logic [7:0]   held_tgt = '0;
  logic [7:0]   held_cmd = '0;
  logic [7:0]   held_len = '0;
  logic [7:0]   pay_idx = '0;
  logic [4:0]   targets = '0;
  int           errors = 0;

  function void set_targets(logic [4:0] v);
    targets = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Advance the frame state by one accepted byte; queue the report it causes.
  function void accept_byte(logic [7:0] b);
    sofr_result_t r;
    logic [7:0]   nxt;
    r.kind            = KIND_PAYLOAD;
    r.target_id       = held_tgt;
    r.command         = held_cmd;
    r.frame_length    = held_len;
    r.position        = pay_idx;
    r.payload_byte    = b;
    r.within_capacity = pay_idx < PAYLOAD_CAPACITY;
    r.frame_done      = 1'b0;
    r.target_valid    = (held_tgt < targets) && (held_tgt < MAX_TARGETS);
    case (phase)
      HUNT_START: begin
        if (b == START_BYTE) phase = GET_TARGET;
      end
      GET_TARGET: begin
        held_tgt = b;
        phase = GET_COMMAND;
      end
      GET_COMMAND: begin
        held_cmd = b;
        phase = GET_LENGTH;
      end
      GET_LENGTH: begin
        held_len = b;
        pay_idx = '0;
        if (b == 8'd0) begin
          // empty frame: one end report with fixed position and data
          r.kind            = KIND_EMPTY_END;
          r.command         = held_cmd;
          r.frame_length    = 8'd0;
          r.position        = 8'd0;
          r.payload_byte    = 8'd0;
          r.within_capacity = 1'b0;
          r.frame_done      = 1'b1;
          expected_q.push_back(r);
          phase = HUNT_START;
        end else begin
          phase = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        nxt = pay_idx + 8'd1;
        r.frame_done = (nxt == held_len);
        expected_q.push_back(r);
        pay_idx = nxt;
        if (r.frame_done) phase = HUNT_START;
      end
      default: phase = HUNT_START;
    endcase
  endfunction

  function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void compare_result(logic [47:0] data, logic last, logic user);
    sofr_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual data %h last %b user %b",
               $time, data, last, user);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    check_field("kind", {7'd0, e.kind}, {7'd0, user});
    check_field("target_id", e.target_id, data[7:0]);
    check_field("command", e.command, data[15:8]);
    check_field("frame_length", e.frame_length, data[23:16]);
    check_field("position", e.position, data[31:24]);
    check_field("payload_byte", e.payload_byte, data[39:32]);
    check_field("within_capacity", {7'd0, e.within_capacity}, {7'd0, data[40]});
    check_field("target_valid", {7'd0, e.target_valid}, {7'd0, data[41]});
    check_field("frame_done", {7'd0, e.frame_done}, {7'd0, last});
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 225;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [TGT_CNT_W-1:0] cfg_wr_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;

  frame_checker board;
  int           cycles = 0;
  int           sent_items = 0;
  int           sink_stall = 0;

  sof_length_frame_receiver uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  // Mostly short stalls, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(15, 30);
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 70) return 8'($urandom_range(1, 8));
    if (r < 90) return 8'($urandom_range(9, 40));
    if (r < 99) return 8'($urandom_range(60, 80));
    return 8'd255;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sink side: random back-pressure with stall-free stretches.
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      out_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if ((cycles % 1536) >= 300 && $urandom_range(0, 99) < 25) sink_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.compare_result(out_tdata, out_tlast, out_tuser);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if ((cycles % 1024) >= 200 && $urandom_range(0, 99) >= 55) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.accept_byte(b);
    sent_items++;
  endtask

  task automatic send_frame(input logic [7:0] len);
    logic [7:0] tgt;
    int         n;
    tgt = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    send_byte(START_BYTE);
    send_byte(tgt);
    send_byte(8'($urandom));
    send_byte(len);
    for (n = 0; n < len; n++)
      send_byte(($urandom_range(0, 15) == 0) ? START_BYTE : 8'($urandom));
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_targets(input logic [4:0] v);
    hold_until_drained();
    // let header bytes still in the pipe clear before the count changes
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_targets(v);
  endtask

  initial begin
    logic [7:0] directed[$];
    logic [4:0] settings[6];
    int         stop_at;
    int         p;
    int         n;
    board = new;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_targets(5'd16);
    directed = '{
      8'h00, 8'hFF, 8'h5A,                          // dropped while hunting
      START_BYTE, 8'h0F, 8'h00, 8'h00,              // empty frame, last valid id
      START_BYTE, 8'h10, 8'hFF, 8'h01, 8'hFF,       // id at the limit
      START_BYTE, 8'hFF, 8'h3C, 8'h02, START_BYTE, 8'h00,  // start byte as payload
      START_BYTE, 8'h00, 8'h81, 8'h01, 8'h7E
    };
    foreach (directed[i]) send_byte(directed[i]);

    settings = '{5'd0, 5'd31, 5'd1, 5'd15, 5'd17, 5'($urandom)};
    for (p = 0; p < 6; p++) begin
      write_targets(settings[p]);
      stop_at = sent_items + PHASE_ITEMS;
      if (p == 2) begin
        // full-length frame reaches the last position and runs past capacity
        send_frame(8'd255);
        hold_until_drained();
      end
      while (sent_items < stop_at) begin
        if ($urandom_range(0, 99) < 85) begin
          send_frame(pick_length());
        end else begin
          for (n = $urandom_range(1, 4); n > 0; n--) send_byte(8'($urandom));
        end
        if ($urandom_range(0, 39) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sofr_pkg.sv
src/sofr_in_stage.sv
src/sofr_parser.sv
src/sofr_out_stage.sv
src/sof_length_frame_receiver.sv
sim/tb_top.sv
